/* rtl/gbba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbba_pkg;

    // geometry of the bitmap
    localparam int GROUP_BLOCKS     = 1024;
    localparam int MAX_GROUPS       = 16;
    localparam int WORD_BITS        = 32;
    localparam int CAPACITY         = GROUP_BLOCKS * MAX_GROUPS;
    localparam int WORDS            = CAPACITY / WORD_BITS;
    localparam int WORDS_PER_GROUP  = GROUP_BLOCKS / WORD_BITS;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int GRP_W   = $clog2(MAX_GROUPS);
    localparam int OFF_W   = $clog2(GROUP_BLOCKS);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WIDX_W  = $clog2(WORDS_PER_GROUP);
    localparam int MEMA_W  = $clog2(WORDS);
    localparam int LEN_W   = OFF_W + 1;
    localparam int TOTAL_W = 15;
    localparam int GCNT_W  = 11;
    localparam int NGRP_W  = 5;
    localparam int SCAN_W  = $clog2(MAX_GROUPS + 1);
    localparam int REQ_ADDR_W = 16;
    localparam int CFG_IDX_W  = 1;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_MISS,
        ST_SCAN_GRP,
        ST_TAKE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic free_rd;
        logic free_wr;
        logic srch_rd;
        logic srch_chk;
        logic srch_next;
        logic miss;
        logic grp_eval;
        logic take;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_free;
        logic in_range;
        logic srch_empty;
        logic hit;
        logic last_word;
        logic phase_scan;
        logic scan_done;
        logic grp_has_free;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/gbba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbba_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire gbba_pkg::sts_t sts,
    output gbba_pkg::cmd_t      cmd
);

    gbba_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbba_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbba_pkg::ST_CLEAR: begin
                if (sts.clr_last) state_next = gbba_pkg::ST_IDLE;
            end
            gbba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (sts.req_free) begin
                        state_next = sts.in_range ? gbba_pkg::ST_FREE_RD : gbba_pkg::ST_DONE;
                    end else begin
                        state_next = sts.in_range ? gbba_pkg::ST_SRCH_RD
                                                  : gbba_pkg::ST_SCAN_GRP;
                    end
                end
            end
            gbba_pkg::ST_FREE_RD:  state_next = gbba_pkg::ST_FREE_WR;
            gbba_pkg::ST_FREE_WR:  state_next = gbba_pkg::ST_DONE;
            gbba_pkg::ST_SRCH_RD: begin
                state_next = sts.srch_empty ? gbba_pkg::ST_MISS : gbba_pkg::ST_SRCH_CHK;
            end
            gbba_pkg::ST_SRCH_CHK: begin
                priority if (sts.hit)  state_next = gbba_pkg::ST_TAKE;
                else if (sts.last_word) state_next = gbba_pkg::ST_MISS;
                else                    state_next = gbba_pkg::ST_SRCH_RD;
            end
            gbba_pkg::ST_MISS:     state_next = gbba_pkg::ST_SCAN_GRP;
            gbba_pkg::ST_SCAN_GRP: begin
                priority if (sts.scan_done) state_next = gbba_pkg::ST_DONE;
                else if (sts.grp_has_free)  state_next = gbba_pkg::ST_SRCH_RD;
                else                        state_next = gbba_pkg::ST_SCAN_GRP;
            end
            gbba_pkg::ST_TAKE:     state_next = gbba_pkg::ST_DONE;
            gbba_pkg::ST_DONE: begin
                if (!sts.out_busy) state_next = gbba_pkg::ST_IDLE;
            end
            default:               state_next = gbba_pkg::ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            gbba_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
            gbba_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            gbba_pkg::ST_FREE_RD:  cmd.free_rd = 1'b1;
            gbba_pkg::ST_FREE_WR:  cmd.free_wr = 1'b1;
            gbba_pkg::ST_SRCH_RD:  cmd.srch_rd = 1'b1;
            gbba_pkg::ST_SRCH_CHK: begin
                cmd.srch_chk  = 1'b1;
                cmd.srch_next = !sts.hit && !sts.last_word;
            end
            gbba_pkg::ST_MISS:     cmd.miss = 1'b1;
            gbba_pkg::ST_SCAN_GRP: cmd.grp_eval = 1'b1;
            gbba_pkg::ST_TAKE:     cmd.take = 1'b1;
            gbba_pkg::ST_DONE:     cmd.finish = !sts.out_busy;
            default:               cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/gbba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbba_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [gbba_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [gbba_pkg::TOTAL_W-1:0]            cfg_wdata,
    input  wire logic                                   s_req_type,
    input  wire logic [gbba_pkg::REQ_ADDR_W-1:0]         s_block_addr,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [1:0]                                  m_status,
    output logic [gbba_pkg::ADDR_W-1:0]                  m_alloc_block,
    output logic [gbba_pkg::TOTAL_W-1:0]                 m_free_total,
    input  wire gbba_pkg::cmd_t                         cmd,
    output gbba_pkg::sts_t                              sts
);

    localparam int WB  = gbba_pkg::WORD_BITS;
    localparam int GW  = gbba_pkg::GRP_W;
    localparam int OW  = gbba_pkg::OFF_W;
    localparam int BW  = gbba_pkg::BIT_W;
    localparam int IW  = gbba_pkg::WIDX_W;
    localparam int LW  = gbba_pkg::LEN_W;
    localparam int TW  = gbba_pkg::TOTAL_W;
    localparam int AW  = gbba_pkg::ADDR_W;
    localparam int MW  = gbba_pkg::MEMA_W;
    localparam int CW  = gbba_pkg::GCNT_W;
    localparam int NW  = gbba_pkg::NGRP_W;
    localparam int SW  = gbba_pkg::SCAN_W;
    localparam int NG  = gbba_pkg::MAX_GROUPS;

    // bitmap memory, one bit per block, set means used
    logic [WB-1:0] mem [gbba_pkg::WORDS];
    logic [WB-1:0] rdata_reg;
    logic [MW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic [WB-1:0] mem_wdata;

    // configuration and per-group state
    logic [TW-1:0] total_blocks_reg;
    logic [NW-1:0] groups_in_use_reg;
    logic [CW-1:0] gcount_reg [NG];
    logic [LW-1:0] hint_reg [NG];
    logic [NG-1:0] known_reg;
    logic [TW-1:0] total_free_reg;
    logic [MW-1:0] clr_reg;

    // request and search state
    logic [AW-1:0] addr_reg;
    logic [GW-1:0] cur_g_reg;
    logic [LW-1:0] from_reg;
    logic [IW-1:0] widx_reg;
    logic [OW-1:0] hit_pos_reg;
    logic          phase_scan_reg;
    logic [SW-1:0] scan_i_reg;
    logic [1:0]    res_status_reg;
    logic [AW-1:0] res_block_reg;

    // output register
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic [AW-1:0] m_alloc_block_reg;
    logic [TW-1:0] m_free_total_reg;

    logic [TW-1:0] eff_total;
    logic [NW-1:0] eff_groups;
    logic [TW-1:0] base;
    logic [TW-1:0] diff;
    logic [LW-1:0] cur_len;
    logic          in_range;
    logic [LW-1:0] word_start;
    logic [LW-1:0] word_end;
    logic [WB-1:0] free_vec;
    logic          hit;
    logic [BW-1:0] hit_bit;
    logic [NW-1:0] g_inc;
    logic [GW-1:0] g_adv;
    logic [LW-1:0] hint_cur;
    logic          known_cur;
    logic [LW-1:0] grp_from;
    logic [LW-1:0] take_pos;
    logic [GW-1:0] a_grp;
    logic [OW-1:0] a_off;

    // effective registers
    always_comb begin
        eff_total  = (total_blocks_reg > TW'(gbba_pkg::CAPACITY))
                   ? TW'(gbba_pkg::CAPACITY) : total_blocks_reg;
        priority if (groups_in_use_reg == '0) eff_groups = NW'(1);
        else if (groups_in_use_reg > NW'(NG)) eff_groups = NW'(NG);
        else eff_groups = groups_in_use_reg;
    end

    // length of the current group
    always_comb begin
        base = {1'b0, cur_g_reg, {OW{1'b0}}};
        diff = eff_total - base;
        priority if (base >= eff_total) cur_len = '0;
        else if (diff > TW'(gbba_pkg::GROUP_BLOCKS)) cur_len = LW'(gbba_pkg::GROUP_BLOCKS);
        else cur_len = diff[LW-1:0];
    end

    assign in_range = s_block_addr < {1'b0, eff_total};
    assign a_grp    = addr_reg[AW-1:OW];
    assign a_off    = addr_reg[OW-1:0];

    // first free bit of the fetched word within the search window
    always_comb begin
        word_start = {1'b0, widx_reg, {BW{1'b0}}};
        word_end   = word_start + LW'(WB);
        for (int j = 0; j < WB; j++) begin
            free_vec[j] = !rdata_reg[j] && ((word_start + LW'(j)) >= from_reg)
                          && ((word_start + LW'(j)) < cur_len);
        end
        hit     = |free_vec;
        hit_bit = '0;
        for (int j = WB - 1; j >= 0; j--) begin
            if (free_vec[j]) hit_bit = BW'(j);
        end
    end

    // next group in the cyclic scan
    always_comb begin
        g_inc     = {{(NW-GW){1'b0}}, cur_g_reg} + NW'(1);
        g_adv     = (g_inc >= eff_groups) ? '0 : g_inc[GW-1:0];
        hint_cur  = hint_reg[cur_g_reg];
        known_cur = known_reg[cur_g_reg];
        grp_from  = known_cur ? hint_cur : '0;
        take_pos  = {1'b0, hit_pos_reg};
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = addr_reg[AW-1:BW];
        mem_wdata = rdata_reg;
        priority if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '1;
        end else if (cmd.free_rd) begin
            mem_re = 1'b1;
        end else if (cmd.free_wr) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_reg & ~(WB'(1) << addr_reg[BW-1:0]);
        end else if (cmd.srch_rd) begin
            mem_re   = 1'b1;
            mem_addr = {cur_g_reg, widx_reg};
        end else if (cmd.take) begin
            mem_we    = 1'b1;
            mem_addr  = {cur_g_reg, hit_pos_reg[OW-1:BW]};
            mem_wdata = rdata_reg | (WB'(1) << hit_pos_reg[BW-1:0]);
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        if (mem_re) rdata_reg <= mem[mem_addr];
    end

    // clearing pass counter and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg           <= '0;
            total_blocks_reg  <= '0;
            groups_in_use_reg <= NW'(1);
        end else begin
            if (cmd.clr_step) clr_reg <= clr_reg + MW'(1);
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gbba_pkg::CFG_TOTAL_BLOCKS:  total_blocks_reg  <= cfg_wdata;
                    gbba_pkg::CFG_GROUPS_IN_USE: groups_in_use_reg <= cfg_wdata[NW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // counts and hints
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_free_reg <= '0;
            known_reg      <= '0;
            for (int g = 0; g < NG; g++) begin
                gcount_reg[g] <= '0;
            end
        end else begin
            if (cmd.free_wr) begin
                total_free_reg    <= total_free_reg + TW'(1);
                gcount_reg[a_grp] <= gcount_reg[a_grp] + CW'(1);
                if (!known_reg[a_grp] || hint_reg[a_grp] > {1'b0, a_off}) begin
                    hint_reg[a_grp]  <= {1'b0, a_off};
                    known_reg[a_grp] <= 1'b1;
                end
            end
            if (cmd.miss && phase_scan_reg && !known_cur) begin
                hint_reg[cur_g_reg]  <= cur_len;
                known_reg[cur_g_reg] <= 1'b1;
            end
            if (cmd.take) begin
                total_free_reg        <= total_free_reg - TW'(1);
                gcount_reg[cur_g_reg] <= gcount_reg[cur_g_reg] - CW'(1);
                if ((phase_scan_reg && !known_cur) || (known_cur && hint_cur == take_pos)) begin
                    hint_reg[cur_g_reg]  <= take_pos + LW'(1);
                    known_reg[cur_g_reg] <= 1'b1;
                end
            end
        end
    end

    // request and search sequencing
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg       <= s_block_addr[AW-1:0];
            res_block_reg  <= '0;
            scan_i_reg     <= '0;
            res_status_reg <= (s_req_type == gbba_pkg::REQ_FREE && !in_range)
                            ? gbba_pkg::STATUS_RANGE : gbba_pkg::STATUS_OK;
            if (in_range) begin
                cur_g_reg      <= s_block_addr[AW-1:OW];
                from_reg       <= {1'b0, s_block_addr[OW-1:0]};
                widx_reg       <= s_block_addr[OW-1:BW];
                phase_scan_reg <= 1'b0;
            end else begin
                cur_g_reg      <= '0;
                phase_scan_reg <= 1'b1;
            end
        end
        if (cmd.srch_chk && hit) begin
            hit_pos_reg <= {widx_reg, hit_bit};
        end
        if (cmd.srch_next) widx_reg <= widx_reg + IW'(1);
        if (cmd.miss) begin
            phase_scan_reg <= 1'b1;
            if (phase_scan_reg) begin
                cur_g_reg  <= g_adv;
                scan_i_reg <= scan_i_reg + SW'(1);
            end
        end
        if (cmd.grp_eval) begin
            priority if (NW'(scan_i_reg) >= eff_groups) begin
                res_status_reg <= gbba_pkg::STATUS_FULL;
            end else if (gcount_reg[cur_g_reg] != '0) begin
                from_reg <= grp_from;
                widx_reg <= grp_from[OW-1:BW];
            end else begin
                cur_g_reg  <= g_adv;
                scan_i_reg <= scan_i_reg + SW'(1);
            end
        end
        if (cmd.take) res_block_reg <= {cur_g_reg, hit_pos_reg};
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            m_status_reg      <= res_status_reg;
            m_alloc_block_reg <= res_block_reg;
            m_free_total_reg  <= total_free_reg;
        end
    end

    // status to the controller
    always_comb begin
        sts.clr_last     = (clr_reg == MW'(gbba_pkg::WORDS - 1));
        sts.req_free     = (s_req_type == gbba_pkg::REQ_FREE);
        sts.in_range     = in_range;
        sts.srch_empty   = (from_reg >= cur_len);
        sts.hit          = hit;
        sts.last_word    = (word_end >= cur_len);
        sts.phase_scan   = phase_scan_reg;
        sts.scan_done    = (NW'(scan_i_reg) >= eff_groups);
        sts.grp_has_free = (gcount_reg[cur_g_reg] != '0);
        sts.out_busy     = m_valid_reg && !m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_alloc_block = m_alloc_block_reg;
    assign m_free_total  = m_free_total_reg;

endmodule

`default_nettype wire

/* rtl/grouped_bitmap_block_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_req_type, s_block_addr, s_batch_last
// m_        out        m_valid / m_ready  m_status, m_alloc_block, m_free_total
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// a free passes the read, write and done states before its result is loaded,
// an out-of-range free only the done state; idle follows before the next item
// an allocate reads and then checks each 32-bit bitmap word, visits a scan
// state for each group looked at in the scan, a miss state after each group
// searched in vain and the take and done states to take the block and load
// the result, all through the single bitmap port; after reset a clearing pass
// over all 512 bitmap words marks every block used; no item is accepted meanwhile
// a finished result waits in the output register while m_ready is low

module grouped_bitmap_block_allocator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [gbba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gbba_pkg::TOTAL_W-1:0]         cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic [gbba_pkg::REQ_ADDR_W-1:0]      s_block_addr,
    input  wire logic                                s_batch_last,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_status,
    output logic [gbba_pkg::ADDR_W-1:0]               m_alloc_block,
    output logic [gbba_pkg::TOTAL_W-1:0]              m_free_total
);

    gbba_pkg::cmd_t cmd;
    gbba_pkg::sts_t sts;

    gbba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gbba_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_req_type    (s_req_type),
        .s_block_addr  (s_block_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_alloc_block (m_alloc_block),
        .m_free_total  (m_free_total),
        .cmd           (cmd),
        .sts           (sts)
    );

    // batch marker has no effect on the allocator
    logic unused_batch;
    assign unused_batch = s_batch_last;

endmodule

`default_nettype wire
